[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Request and response structs, the stored entry layout and the status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              operation;
		logic signed [31:0] value;
		logic signed [31:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
	} rsp_t;

	// Priority in the upper half, value in the lower half.
	typedef struct packed {
		logic signed [31:0] prio;
		logic signed [31:0] value;
	} entry_t;

	typedef struct packed {
		logic   en;
		entry_t data;
	} wr_ctl_t;

endpackage

[hw/rtl/spq_store.sv]
// ----------------------------------------------------------------------------
// spq_store: entry memory of the sorted priority queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_store #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  spq_pkg::wr_ctl_t          wr,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output spq_pkg::entry_t           rdata
);

	spq_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[waddr] <= wr.data;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Each request walks the sequencer: an insert compares entries from the tail, moving each
// one of lower or equal priority down, then writes the new entry; a remove moves the entries
// behind the head up. A dropped insert, or a remove that leaves or finds the queue empty,
// skips the walk. One request at a time, taken in the cycle after the previous response is
// loaded, which waits while the response register is held; each visit reads, then writes.
// Reset (arst_n low, asynchronous) empties the queue at once; the memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in descending order
// A small sequencer walks the entry memory, using one signed priority compare
// to place inserts and one move path to close the gap left by removals.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_INS_RD    = 4'd1;
	localparam logic [3:0] S_INS_CMP   = 4'd2;
	localparam logic [3:0] S_INS_PUT   = 4'd3;
	localparam logic [3:0] S_REM_RD    = 4'd4;
	localparam logic [3:0] S_REM_WR    = 4'd5;
	localparam logic [3:0] S_HEAD_RD   = 4'd6;
	localparam logic [3:0] S_HEAD_WAIT = 4'd7;
	localparam logic [3:0] S_DONE      = 4'd8;

	logic [3:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [1:0]      status_q;
	logic            rsp_valid_q;
	spq_pkg::req_t   item_q;
	spq_pkg::entry_t head_q;
	spq_pkg::rsp_t   rsp_q;

	logic             req_take;
	logic             rsp_free;
	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    idx_m1;
	logic             prio_le;
	logic [31:0]      count_wide;
	spq_pkg::entry_t  new_entry;
	spq_pkg::entry_t  rdata;
	spq_pkg::wr_ctl_t wr;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;

	// A new request is taken only while the sequencer is idle.
	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && (state_q == S_IDLE);

	// The response register is free when empty or being drained this cycle.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);

	assign new_entry.prio  = item_q.priority_req;
	assign new_entry.value = item_q.value;

	// The shared compare: a stored entry whose priority is not greater than
	// the new one moves down one place, so equal priorities put the newest
	// entry ahead.
	assign prio_le = (rdata.prio <= item_q.priority_req);

	assign count_wide = 32'(count_q);

	// Memory access for the current step.
	always_comb begin
		wr.en   = 1'b0;
		wr.data = new_entry;
		waddr   = '0;
		raddr   = idx_q[AW-1:0];
		unique case (state_q)
			S_INS_CMP: begin
				wr.en = 1'b1;
				waddr = idx_p1[AW-1:0];
				if (prio_le) begin
					wr.data = rdata;
				end
			end
			S_INS_PUT: begin
				wr.en = 1'b1;
				waddr = '0;
			end
			S_REM_WR: begin
				wr.en   = 1'b1;
				wr.data = rdata;
				waddr   = idx_m1[AW-1:0];
			end
			S_HEAD_RD: begin
				raddr = '0;
			end
			default: begin
			end
		endcase
	end

	spq_store #(
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.wr   (wr),
		.waddr(waddr),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			status_q    <= spq_pkg::ST_DONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						status_q <= spq_pkg::ST_DONE;
						if (req.operation == spq_pkg::OP_INSERT) begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								status_q <= spq_pkg::ST_FULL;
								state_q  <= S_HEAD_RD;
							end else if (count_q == '0) begin
								state_q <= S_INS_PUT;
							end else begin
								idx_q   <= count_q - CW'(1);
								state_q <= S_INS_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= spq_pkg::ST_EMPTY;
								state_q  <= S_HEAD_RD;
							end else if (count_q == CW'(1)) begin
								count_q <= '0;
								state_q <= S_HEAD_RD;
							end else begin
								idx_q   <= CW'(1);
								state_q <= S_REM_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (prio_le) begin
						if (idx_q == '0) begin
							state_q <= S_INS_PUT;
						end else begin
							idx_q   <= idx_m1;
							state_q <= S_INS_RD;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_HEAD_RD;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_HEAD_RD;
				end
				S_REM_RD: begin
					state_q <= S_REM_WR;
				end
				S_REM_WR: begin
					if (idx_p1 == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_HEAD_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_REM_RD;
					end
				end
				S_HEAD_RD: begin
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_HEAD_WAIT;
					end
				end
				S_HEAD_WAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the request being worked on, the head entry read
	// back at the end, and the response presented to the consumer.
	always_ff @(posedge clk) begin
		if (req_take) begin
			item_q <= req;
		end
		if (state_q == S_HEAD_RD && count_q == '0) begin
			head_q <= '0;
		end
		if (state_q == S_HEAD_WAIT) begin
			head_q <= rdata;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.status        <= status_q;
			rsp_q.entry_count   <= count_wide[4:0];
			rsp_q.is_empty      <= (count_q == '0);
			rsp_q.head_value    <= head_q.value;
			rsp_q.head_priority <= head_q.prio;
		end
	end

endmodule

[verif/spq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: response checker for the sorted priority queue
// Keeps its own sorted copy of the queue, works out the response to every
// accepted request and compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  spq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  spq_pkg::rsp_t rsp,
	output int            errors,
	output int            outstanding
);

	spq_pkg::entry_t queue_copy [QUEUE_DEPTH];
	int              queue_fill = 0;
	spq_pkg::rsp_t   awaited_rsp [$];
	int              n_bad = 0;
	int              n_open = 0;

	assign errors      = n_bad;
	assign outstanding = n_open;

	// Applies one request to the local copy and returns the response it earns.
	function automatic spq_pkg::rsp_t serve_request(spq_pkg::req_t r);
		spq_pkg::rsp_t res;
		int            pos;
		bit            found;
		res = '0;
		res.status = spq_pkg::ST_DONE;
		if (r.operation == spq_pkg::OP_INSERT) begin
			if (queue_fill >= QUEUE_DEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				pos = queue_fill;
				found = 1'b0;
				for (int i = 0; i < queue_fill; i++) begin
					if (!found && $signed(queue_copy[i].prio) <= $signed(r.priority_req)) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (int i = queue_fill; i > pos; i--)
					queue_copy[i] = queue_copy[i - 1];
				queue_copy[pos].prio  = r.priority_req;
				queue_copy[pos].value = r.value;
				queue_fill++;
			end
		end else begin
			if (queue_fill == 0) begin
				res.status = spq_pkg::ST_EMPTY;
			end else begin
				for (int i = 1; i < queue_fill; i++)
					queue_copy[i - 1] = queue_copy[i];
				queue_fill--;
			end
		end
		res.entry_count = 5'(queue_fill);
		res.is_empty    = (queue_fill == 0);
		if (queue_fill != 0) begin
			res.head_value    = queue_copy[0].value;
			res.head_priority = queue_copy[0].prio;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spq_pkg::rsp_t want;
		bit            bad;
		if (!arst_n) begin
			queue_fill = 0;
			awaited_rsp.delete();
			n_open <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("spq: response at %0t with no request outstanding", $time);
				end else begin
					want = awaited_rsp.pop_front();
					bad = (rsp.status !== want.status) ||
						(rsp.entry_count !== want.entry_count) ||
						(rsp.is_empty !== want.is_empty) ||
						(rsp.head_value !== want.head_value) ||
						(rsp.head_priority !== want.head_priority);
					if (bad) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("spq: mismatch at %0t (expected/actual): status %0d/%0d",
								$time, want.status, rsp.status);
							$display("spq:   count %0d/%0d empty %0d/%0d value %0d/%0d prio %0d/%0d",
								want.entry_count, rsp.entry_count,
								want.is_empty, rsp.is_empty,
								want.head_value, rsp.head_value,
								want.head_priority, rsp.head_priority);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				awaited_rsp.push_back(serve_request(req));
			n_open <= awaited_rsp.size();
		end
	end

endmodule

[verif/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: testbench of the sorted priority queue
// Drives a short directed sequence and then phases of random inserts and
// removes with random gaps and stalls; a separate checker predicts and
// compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

	localparam int DEPTH        = 16;
	localparam int N_ITEMS      = 1150;
	// Longest legal quiet spell is the long receiver hold-off plus one request's
	// latency, so the watchdog limit is set above the hold-off.
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 60;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	spq_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	spq_pkg::rsp_t rsp;

	int errors;
	int outstanding;
	int sent        = 0;
	int hold_asked  = 0;
	int hold_done   = 0;
	int idle_cycles = 0;
	bit no_gaps     = 1'b0;

	sorted_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	spq_checker #(
		.QUEUE_DEPTH(DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Random 32-bit word for a value or a priority. A fair share comes from a
	// narrow band around zero so that equal priorities turn up often, and a
	// few are the signed extremes, zero or all ones.
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom;
		else if (r < 8)
			return 32'($urandom_range(0, 6)) - 32'd3;
		else begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
	endfunction

	// Offers one request, holds it steady until the queue takes it and then
	// may leave a random gap. With no gap the valid simply stays high for the next
	// request, so it is never lowered and raised within one step.
	task automatic send(logic op, logic [31:0] val, logic [31:0] pri);
		int r;
		req_valid <= 1'b1;
		req <= '{operation: op, value: val, priority_req: pri};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
		r = $urandom_range(0, 99);
		if (!no_gaps && r >= 45) begin
			req_valid <= 1'b0;
			repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40))
				@(posedge clk);
		end
	endtask

	// Stops offering and waits until every response has come back. The first
	// edge lets the checker's count catch up with the last request taken.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Sender: directed opening, then random phases, then the verdict.
	initial begin
		int  phase;
		int  phase_len;
		int  insert_pct;
		phase = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// A remove from the empty queue must be ignored and flagged.
		send(spq_pkg::OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
		// Signed extremes of both fields, so that the compare is seen to be signed.
		send(spq_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
		send(spq_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		send(spq_pkg::OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
		send(spq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		// Equal priorities: the newest entry must go ahead of the older one.
		send(spq_pkg::OP_INSERT, 32'h0000_0001, 32'h0000_0000);
		send(spq_pkg::OP_INSERT, 32'h0000_0002, 32'h8000_0000);
		send(spq_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		send(spq_pkg::OP_REMOVE, 32'h5555_5555, 32'haaaa_aaaa);
		// Fill the queue to the brim, then try one insert too many.
		repeat (DEPTH - 4)
			send(spq_pkg::OP_INSERT, $urandom, pick_word());
		send(spq_pkg::OP_INSERT, 32'h1234_5678, 32'h7fff_ffff);

		// Random phases, each leaning towards inserts or removes so that the
		// queue keeps swinging between full and empty.
		while (sent < N_ITEMS) begin
			phase++;
			phase_len = $urandom_range(10, 60);
			case ($urandom_range(0, 3))
				0: insert_pct = 20;
				1: insert_pct = 50;
				2: insert_pct = 80;
				default: insert_pct = 95;
			endcase
			no_gaps = ($urandom_range(0, 4) == 0);
			// Once, the receiver holds off for a long stretch while requests keep
			// coming back to back, so the queue has to stall its input.
			if (phase == 4) begin
				hold_asked++;
				no_gaps = 1'b1;
				insert_pct = 50;
			end
			repeat (phase_len)
				send(($urandom_range(0, 99) < insert_pct) ?
					spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE,
					pick_word(), pick_word());
			// Now and then the sender pauses until the queue has answered everything.
			if (phase % 7 == 3)
				wait_drained();
		end

		no_gaps = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Receiver: runs of free flow and of stalls, most stalls short and a few
	// long, plus the one long hold-off that the sender asks for.
	initial begin
		int r;
		@(posedge clk);
		forever begin
			if (hold_asked != hold_done) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					rsp_stall <= 1'b0;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end else if (r < 92) begin
					rsp_stall <= ~rsp_stall;
					@(posedge clk);
				end else begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: any cycle in which neither channel moves a request or a
	// response counts towards the limit.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
